// ===== design/multi_channel_debouncer_macros.svh =====
// Assertion macros for the multi-channel debouncer checker.
// Depends on nothing; included by the checker file.
`ifndef MULTI_CHANNEL_DEBOUNCER_MACROS_SVH
`define MULTI_CHANNEL_DEBOUNCER_MACROS_SVH

// same-cycle implication, disabled during reset
`define DBNC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define DBNC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/dbnc_pkg.sv =====
// Shared types and constants of the multi-channel debouncer.
// Used by the interfaces, datapath, controller and top level.
package dbnc_pkg;

  localparam int unsigned NUM_CHANNELS_DEF = 8;
  localparam int unsigned LVL_W            = 8;
  localparam int unsigned TIME_W           = 32;
  localparam int unsigned DEB_W            = 16;
  localparam int unsigned EVT_CH_W         = 3;
  localparam int unsigned CFG_IDX_W        = 8;
  localparam int unsigned CFG_DATA_W       = 32;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CH_ENABLE   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_HIGH = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_GLOBAL_EN   = CFG_IDX_W'(3);

  localparam logic [DEB_W-1:0] DEBOUNCE_RST = DEB_W'(50);

  localparam logic CMD_SEED   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_EMIT
  } dbnc_state_e;

  typedef struct packed {
    logic latch;
    logic seed;
    logic step;
    logic load;
    logic idx_clr;
    logic idx_inc;
  } dbnc_cmd_t;

  typedef struct packed {
    logic is_seed;
    logic gen_en;
    logic idx_last;
    logic fire_cur;
    logic out_free;
  } dbnc_status_t;

endpackage

// ===== design/dbnc_in_if.sv =====
// Input request channel: command, raw channel levels and millisecond time.
// Depends on dbnc_pkg for field widths.
interface dbnc_in_if;
  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic [dbnc_pkg::LVL_W-1:0]  raw_levels;
  logic [dbnc_pkg::TIME_W-1:0] now_ms;

  modport source (output valid, cmd, raw_levels, now_ms, input ready);
  modport sink   (input valid, cmd, raw_levels, now_ms, output ready);
endinterface

// ===== design/dbnc_out_if.sv =====
// Event channel: one request per debounced press or release.
// Depends on dbnc_pkg for field widths.
interface dbnc_out_if;
  logic                          valid;
  logic                          ready;
  logic [dbnc_pkg::EVT_CH_W-1:0] event_channel;
  logic                          event_pressed;
  logic                          event_last;

  modport source (output valid, event_channel, event_pressed, event_last, input ready);
  modport sink   (input valid, event_channel, event_pressed, event_last, output ready);
endinterface

// ===== design/dbnc_cfg_if.sv =====
// Configuration write channel: register index and write data.
// Depends on dbnc_pkg for field widths.
interface dbnc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [dbnc_pkg::CFG_IDX_W-1:0]  index;
  logic [dbnc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/dbnc_dp.sv =====
// Debouncer datapath: config registers, per-channel state, scan index,
// event flags and the output register. Depends on dbnc_pkg.
module dbnc_dp #(
  parameter int unsigned NUM_CHANNELS = dbnc_pkg::NUM_CHANNELS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  dbnc_pkg::dbnc_cmd_t               cmd_i,
  output dbnc_pkg::dbnc_status_t            status_o,
  input  logic                              in_cmd_i,
  input  logic [dbnc_pkg::LVL_W-1:0]        in_raw_i,
  input  logic [dbnc_pkg::TIME_W-1:0]       in_now_i,
  input  logic                              cfg_valid_i,
  input  logic [dbnc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [dbnc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output logic                              cfg_ready_o,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [dbnc_pkg::EVT_CH_W-1:0]     out_channel_o,
  output logic                              out_pressed_o,
  output logic                              out_last_o
);

  localparam int unsigned CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic [dbnc_pkg::DEB_W-1:0]  deb_q;
  logic [dbnc_pkg::LVL_W-1:0]  en_mask_q;
  logic [dbnc_pkg::LVL_W-1:0]  ah_mask_q;
  logic                        gen_en_q;

  logic                        cmd_q;
  logic [NUM_CHANNELS-1:0]     corr_q;
  logic [dbnc_pkg::TIME_W-1:0] now_q;

  logic [NUM_CHANNELS-1:0]     conf_q;
  logic [NUM_CHANNELS-1:0]     pend_q;
  logic [dbnc_pkg::TIME_W-1:0] stamp_q [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0]     fire_q;
  logic [CH_W-1:0]             idx_q;

  logic                          out_valid_q;
  logic [dbnc_pkg::EVT_CH_W-1:0] out_ch_q;
  logic                          out_pressed_q;
  logic                          out_last_q;

  logic [NUM_CHANNELS-1:0]     en_vec;
  logic [NUM_CHANNELS-1:0]     corr_in;
  logic [NUM_CHANNELS-1:0]     above;

  logic                        s_cur;
  logic                        changed;
  logic [dbnc_pkg::TIME_W-1:0] stamp_eff;
  logic [dbnc_pkg::TIME_W-1:0] elapsed;
  logic                        fire_step;
  logic                        out_free;
  logic                        last_cur;

  for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_ch
    if (i < dbnc_pkg::LVL_W) begin : g_mapped
      assign en_vec[i]  = en_mask_q[i];
      assign corr_in[i] = ~(in_raw_i[i] ^ ah_mask_q[i]);
    end else begin : g_unmapped
      assign en_vec[i]  = 1'b0;
      assign corr_in[i] = 1'b1;
    end
  end

  always_comb begin
    for (int j = 0; j < NUM_CHANNELS; j++) begin
      above[j] = (j > int'(idx_q));
    end
  end

  assign s_cur     = corr_q[idx_q];
  assign changed   = s_cur != pend_q[idx_q];
  assign stamp_eff = changed ? now_q : stamp_q[idx_q];
  assign elapsed   = now_q - stamp_eff;
  assign fire_step = en_vec[idx_q] && (s_cur != conf_q[idx_q]) &&
                     (elapsed >= dbnc_pkg::TIME_W'(deb_q));
  assign out_free  = !out_valid_q || out_ready_i;
  assign last_cur  = ~|(fire_q & above);

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_q     <= dbnc_pkg::DEBOUNCE_RST;
      en_mask_q <= '0;
      ah_mask_q <= '0;
      gen_en_q  <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        dbnc_pkg::REG_DEBOUNCE_MS: deb_q     <= cfg_data_i[dbnc_pkg::DEB_W-1:0];
        dbnc_pkg::REG_CH_ENABLE:   en_mask_q <= cfg_data_i[dbnc_pkg::LVL_W-1:0];
        dbnc_pkg::REG_ACTIVE_HIGH: ah_mask_q <= cfg_data_i[dbnc_pkg::LVL_W-1:0];
        dbnc_pkg::REG_GLOBAL_EN:   gen_en_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      cmd_q  <= in_cmd_i;
      corr_q <= corr_in;
      now_q  <= in_now_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conf_q <= '0;
      pend_q <= '0;
      fire_q <= '0;
      idx_q  <= '0;
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        stamp_q[k] <= '0;
      end
    end else begin
      if (cmd_i.latch) begin
        fire_q <= '0;
      end
      if (cmd_i.seed) begin
        for (int k = 0; k < NUM_CHANNELS; k++) begin
          if (en_vec[k]) begin
            conf_q[k]  <= corr_q[k];
            pend_q[k]  <= corr_q[k];
            stamp_q[k] <= now_q;
          end
        end
      end
      if (cmd_i.step) begin
        fire_q[idx_q] <= fire_step;
        if (en_vec[idx_q]) begin
          pend_q[idx_q]  <= s_cur;
          stamp_q[idx_q] <= stamp_eff;
          if (fire_step) begin
            conf_q[idx_q] <= s_cur;
          end
        end
      end
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + CH_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_ch_q      <= dbnc_pkg::EVT_CH_W'(idx_q);
      out_pressed_q <= s_cur;
      out_last_q    <= last_cur;
    end
  end

  assign status_o.is_seed  = cmd_q == dbnc_pkg::CMD_SEED;
  assign status_o.gen_en   = gen_en_q;
  assign status_o.idx_last = idx_q == CH_W'(NUM_CHANNELS - 1);
  assign status_o.fire_cur = fire_q[idx_q];
  assign status_o.out_free = out_free;

  assign out_valid_o   = out_valid_q;
  assign out_channel_o = out_ch_q;
  assign out_pressed_o = out_pressed_q;
  assign out_last_o    = out_last_q;

endmodule

// ===== design/dbnc_ctrl.sv =====
// Debouncer controller: sequences accept, seed, channel scan and event emit.
// Depends on dbnc_pkg for the state enum and command/status structs.
module dbnc_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  dbnc_pkg::dbnc_status_t status_i,
  output dbnc_pkg::dbnc_cmd_t    cmd_o
);

  dbnc_pkg::dbnc_state_e state_q, state_d;
  logic                  advance;

  assign advance = !status_i.fire_cur || status_i.out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dbnc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      dbnc_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = dbnc_pkg::ST_DISPATCH;
      end
      dbnc_pkg::ST_DISPATCH: begin
        if (status_i.is_seed || !status_i.gen_en) state_d = dbnc_pkg::ST_IDLE;
        else state_d = dbnc_pkg::ST_SCAN;
      end
      dbnc_pkg::ST_SCAN: begin
        if (status_i.idx_last) state_d = dbnc_pkg::ST_EMIT;
      end
      dbnc_pkg::ST_EMIT: begin
        if (advance && status_i.idx_last) state_d = dbnc_pkg::ST_IDLE;
      end
      default: state_d = dbnc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      dbnc_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.latch   = in_valid_i;
        cmd_o.idx_clr = 1'b1;
      end
      dbnc_pkg::ST_DISPATCH: begin
        cmd_o.seed = status_i.is_seed;
      end
      dbnc_pkg::ST_SCAN: begin
        cmd_o.step    = 1'b1;
        cmd_o.idx_clr = status_i.idx_last;
        cmd_o.idx_inc = !status_i.idx_last;
      end
      dbnc_pkg::ST_EMIT: begin
        cmd_o.load    = status_i.fire_cur && status_i.out_free;
        cmd_o.idx_inc = advance && !status_i.idx_last;
      end
      default: ;
    endcase
  end

endmodule

// ===== design/multi_channel_debouncer.sv =====
// Multi-channel debouncer top level: controller plus datapath.
// Depends on dbnc_pkg, the three channel interfaces, dbnc_ctrl and dbnc_dp.
//
// Usage:
//   in_i  takes one request per millisecond tick: cmd (seed or sample),
//         raw_levels (bit per channel) and now_ms.
//   out_o gives one request per debounced press/release, in ascending
//         channel order; event_last marks the final event of a tick.
//   cfg_i writes the debounce time (0), channel_enable_mask (1),
//         active_high_mask (2) and global_enable (3); always ready,
//         other indexes are dropped. Write only while idle.
// Sequence: a sample request passes a dispatch state, then scans each channel
//   through the shared compare unit, then walks each channel in the emit
//   state; a seed request, or a sample while globally disabled, returns to
//   idle from dispatch.
// Stall: the emit walk holds on a channel while the output register is
//   full and not taken; the next request is accepted while the final event
//   still waits. Reset clears all channel state to released, timestamps to
//   zero and the registers to their defaults.
module multi_channel_debouncer #(
  parameter int unsigned NUM_CHANNELS = dbnc_pkg::NUM_CHANNELS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dbnc_in_if.sink    in_i,
  dbnc_out_if.source out_o,
  dbnc_cfg_if.sink   cfg_i
);

  dbnc_pkg::dbnc_cmd_t    ctrl_cmd;
  dbnc_pkg::dbnc_status_t dp_status;

  dbnc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (dp_status),
    .cmd_o      (ctrl_cmd)
  );

  dbnc_dp #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (ctrl_cmd),
    .status_o      (dp_status),
    .in_cmd_i      (in_i.cmd),
    .in_raw_i      (in_i.raw_levels),
    .in_now_i      (in_i.now_ms),
    .cfg_valid_i   (cfg_i.valid),
    .cfg_index_i   (cfg_i.index),
    .cfg_data_i    (cfg_i.data),
    .cfg_ready_o   (cfg_i.ready),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .out_channel_o (out_o.event_channel),
    .out_pressed_o (out_o.event_pressed),
    .out_last_o    (out_o.event_last)
  );

endmodule

// ===== design/dbnc_checker.sv =====
// Port-level checker for the multi-channel debouncer, bound to the top.
// Depends on multi_channel_debouncer_macros.svh and dbnc_pkg widths.
`include "multi_channel_debouncer_macros.svh"

module dbnc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [dbnc_pkg::EVT_CH_W-1:0] evt_channel_i,
  input logic                          evt_pressed_i,
  input logic                          evt_last_i
);

  `DBNC_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable({evt_channel_i, evt_pressed_i, evt_last_i}), "event dropped or changed while stalled")
  `DBNC_ASSERT_IMP(a_no_accept_mid_burst, clk_i, rst_ni, out_valid_i && !evt_last_i, !in_ready_i, "request accepted before final event of previous tick")
  `DBNC_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i, "ready right after an accepted request")

endmodule

bind multi_channel_debouncer dbnc_checker u_dbnc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .evt_channel_i (out_o.event_channel),
  .evt_pressed_i (out_o.event_pressed),
  .evt_last_i    (out_o.event_last)
);

// ===== tb/multi_channel_debouncer_tb.sv =====
// Testbench for multi_channel_debouncer: directed and random tick requests
// checked against a per-channel debounce tracker. Depends on dbnc_pkg, the
// dbnc_in_if, dbnc_out_if and dbnc_cfg_if interfaces, and the top level.
module multi_channel_debouncer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CFG_IDX_W  = dbnc_pkg::CFG_IDX_W;
  localparam int unsigned CFG_DATA_W = dbnc_pkg::CFG_DATA_W;
  localparam int unsigned EVT_CH_W   = dbnc_pkg::EVT_CH_W;
  localparam int unsigned DEB_W      = dbnc_pkg::DEB_W;
  localparam int unsigned LVL_W      = dbnc_pkg::LVL_W;
  localparam int unsigned TIME_W     = dbnc_pkg::TIME_W;

  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = CFG_IDX_W'(255);
  localparam int unsigned          NCH             = dbnc_pkg::NUM_CHANNELS_DEF;

  typedef struct packed {
    logic [EVT_CH_W-1:0] channel;
    logic                pressed;
    logic                last;
  } key_event_t;

  class debounce_tracker;
    logic [DEB_W-1:0]  settle_ms;
    logic [LVL_W-1:0]  enable_mask;
    logic [LVL_W-1:0]  active_high;
    logic              global_en;
    logic              confirmed [NCH];
    logic              pending_lvl [NCH];
    logic [TIME_W-1:0] since_ms [NCH];
    key_event_t        expected_events[$];
    int                mismatches;

    function new();
      settle_ms   = dbnc_pkg::DEBOUNCE_RST;
      enable_mask = '0;
      active_high = '0;
      global_en   = 1'b1;
      mismatches  = 0;
      for (int ch = 0; ch < NCH; ch++) begin
        confirmed[ch]   = 1'b0;
        pending_lvl[ch] = 1'b0;
        since_ms[ch]    = '0;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        dbnc_pkg::REG_DEBOUNCE_MS: settle_ms   = data[DEB_W-1:0];
        dbnc_pkg::REG_CH_ENABLE:   enable_mask = data[LVL_W-1:0];
        dbnc_pkg::REG_ACTIVE_HIGH: active_high = data[LVL_W-1:0];
        dbnc_pkg::REG_GLOBAL_EN:   global_en   = data[0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_events.size();
    endfunction

    function void note_request(logic cmd, logic [LVL_W-1:0] lv, logic [TIME_W-1:0] now);
      key_event_t        ev;
      logic              lvl;
      logic [TIME_W-1:0] held;
      int                n;
      n = 0;
      for (int ch = 0; ch < NCH; ch++) begin
        if (!enable_mask[ch]) continue;
        lvl = active_high[ch] ? lv[ch] : ~lv[ch];
        if (cmd == dbnc_pkg::CMD_SEED) begin
          confirmed[ch]   = lvl;
          pending_lvl[ch] = lvl;
          since_ms[ch]    = now;
        end else if (global_en) begin
          if (lvl != pending_lvl[ch]) begin
            pending_lvl[ch] = lvl;
            since_ms[ch]    = now;
          end
          held = now - since_ms[ch];
          if (pending_lvl[ch] != confirmed[ch] && held >= TIME_W'(settle_ms)) begin
            confirmed[ch] = pending_lvl[ch];
            ev.channel = EVT_CH_W'(ch);
            ev.pressed = confirmed[ch];
            ev.last    = 1'b0;
            expected_events.push_back(ev);
            n++;
          end
        end
      end
      if (n > 0) begin
        ev = expected_events.pop_back();
        ev.last = 1'b1;
        expected_events.push_back(ev);
      end
    endfunction

    function void check_event(logic [EVT_CH_W-1:0] ch, logic pressed, logic last);
      key_event_t want;
      if (expected_events.size() == 0) begin
        $error("unexpected event: channel %0d pressed %0b last %0b", ch, pressed, last);
        mismatches++;
        return;
      end
      want = expected_events.pop_front();
      if (ch !== want.channel) begin
        $error("event_channel: expected %0d, actual %0d", want.channel, ch);
        mismatches++;
      end
      if (pressed !== want.pressed) begin
        $error("event_pressed: expected %0b, actual %0b", want.pressed, pressed);
        mismatches++;
      end
      if (last !== want.last) begin
        $error("event_last: expected %0b, actual %0b", want.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   steady;
  bit   hold_req;

  debounce_tracker tracker = new();

  dbnc_in_if  in_if ();
  dbnc_out_if out_if ();
  dbnc_cfg_if cfg_if ();

  multi_channel_debouncer dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #(2_000_000);
    $display("multi_channel_debouncer_tb NOT OK");
    $finish;
  end

  initial begin
    int hold_left;
    hold_left = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_if.valid && out_if.ready)
        tracker.check_event(out_if.event_channel, out_if.event_pressed, out_if.event_last);
      if (hold_left == 0 && hold_req) begin
        hold_req  = 1'b0;
        hold_left = 400;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= steady || ($urandom_range(0, 99) >= 31);
      end
    end
  end

  task automatic send_request(input logic cmd, input logic [LVL_W-1:0] lv,
                              input logic [TIME_W-1:0] now);
    while (!steady && $urandom_range(0, 99) < 31) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.cmd        <= cmd;
    in_if.raw_levels <= lv;
    in_if.now_ms     <= now;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    tracker.note_request(cmd, lv, now);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    tracker.write_reg(idx, data);
  endtask

  task automatic cfg_release();
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [DEB_W-1:0] deb, input logic [LVL_W-1:0] en,
                           input logic [LVL_W-1:0] ah, input logic ge);
    write_reg(dbnc_pkg::REG_DEBOUNCE_MS, CFG_DATA_W'(deb));
    write_reg(dbnc_pkg::REG_CH_ENABLE, CFG_DATA_W'(en));
    write_reg(dbnc_pkg::REG_ACTIVE_HIGH, CFG_DATA_W'(ah));
    write_reg(dbnc_pkg::REG_GLOBAL_EN, CFG_DATA_W'(ge));
    cfg_release();
  endtask

  task automatic wait_drained(input int extra);
    in_if.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic random_phase(input int n, input logic [DEB_W-1:0] deb,
                              input logic [LVL_W-1:0] en, input logic [LVL_W-1:0] ah,
                              input logic ge, input bit hold, input bit pause);
    logic [LVL_W-1:0]  target;
    logic [LVL_W-1:0]  chg;
    logic [LVL_W-1:0]  lv;
    logic [TIME_W-1:0] t;
    int                bounce_left;
    int                r;
    int unsigned       step_max;
    configure(deb, en, ah, ge);
    target      = LVL_W'($urandom);
    t           = $urandom;
    chg         = '0;
    bounce_left = 0;
    step_max    = deb / 3 + 2;
    if (hold) hold_req = 1'b1;
    send_request(dbnc_pkg::CMD_SEED, target, t);
    for (int i = 0; i < n; i++) begin
      if (pause && i == n / 2) wait_drained(1);
      r = $urandom_range(0, 99);
      if (r < 6) begin
        target = LVL_W'($urandom);
        send_request(dbnc_pkg::CMD_SEED, target, t);
      end else if (r < 10) begin
        t = $urandom;
        send_request(dbnc_pkg::CMD_SAMPLE, LVL_W'($urandom), t);
      end else begin
        if ($urandom_range(0, 3) == 0) begin
          chg = LVL_W'($urandom & $urandom);
          if (chg == '0) chg = LVL_W'(1) << $urandom_range(0, LVL_W - 1);
          target      = target ^ chg;
          bounce_left = $urandom_range(0, 3);
        end
        lv = target;
        if (bounce_left > 0) begin
          lv = lv ^ (chg & LVL_W'($urandom));
          bounce_left--;
        end
        if ($urandom_range(0, 9) == 0) t = t + deb + $urandom_range(0, 2);
        else t = t + $urandom_range(0, step_max);
        send_request(dbnc_pkg::CMD_SAMPLE, lv, t);
      end
    end
    wait_drained(24);
  endtask

  initial begin
    steady           = 1'b0;
    hold_req         = 1'b0;
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.cmd        = dbnc_pkg::CMD_SEED;
    in_if.raw_levels = '0;
    in_if.now_ms     = '0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = dbnc_pkg::REG_DEBOUNCE_MS;
    cfg_if.data      = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: nothing enabled
    send_request(dbnc_pkg::CMD_SAMPLE, 8'hFF, 32'd100);
    send_request(dbnc_pkg::CMD_SEED, 8'h00, 32'd0);
    wait_drained(24);

    configure(16'd0, 8'hFF, 8'hA5, 1'b1);
    write_reg(REG_UNMAPPED_LO, 32'h0000_1234);
    write_reg(REG_UNMAPPED_HI, 32'hFFFF_FFFF);
    cfg_release();
    send_request(dbnc_pkg::CMD_SEED, 8'h00, 32'd0);
    send_request(dbnc_pkg::CMD_SAMPLE, 8'hFF, 32'd0);
    send_request(dbnc_pkg::CMD_SAMPLE, 8'h00, 32'd1);
    send_request(dbnc_pkg::CMD_SAMPLE, 8'hFF, 32'hFFFF_FFFF);
    send_request(dbnc_pkg::CMD_SAMPLE, 8'h0F, 32'd0);
    wait_drained(24);

    // oversized writes keep only the low bits; global enable drops to zero
    write_reg(dbnc_pkg::REG_DEBOUNCE_MS, 32'hFFFF_FFFF);
    write_reg(dbnc_pkg::REG_CH_ENABLE, 32'h0000_003C);
    write_reg(dbnc_pkg::REG_ACTIVE_HIGH, 32'h0000_01FF);
    write_reg(dbnc_pkg::REG_GLOBAL_EN, 32'h0000_0002);
    cfg_release();
    send_request(dbnc_pkg::CMD_SAMPLE, 8'hFF, 32'd5);
    send_request(dbnc_pkg::CMD_SEED, 8'h00, 32'hFFFF_F000);
    send_request(dbnc_pkg::CMD_SAMPLE, 8'h3C, 32'hFFFF_F010);
    wait_drained(24);

    write_reg(dbnc_pkg::REG_GLOBAL_EN, 32'h0000_0001);
    cfg_release();
    send_request(dbnc_pkg::CMD_SAMPLE, 8'h3C, 32'hFFFF_F100);
    send_request(dbnc_pkg::CMD_SAMPLE, 8'h3C, 32'h0000_F0FE);
    send_request(dbnc_pkg::CMD_SAMPLE, 8'h3C, 32'h0000_F0FF);
    send_request(dbnc_pkg::CMD_SAMPLE, 8'h18, 32'h0000_F100);
    send_request(dbnc_pkg::CMD_SEED, 8'hC3, 32'h0000_0010);
    send_request(dbnc_pkg::CMD_SAMPLE, 8'hFF, 32'h0000_0010);
    wait_drained(24);

    random_phase(42, 16'd0, 8'hFF, LVL_W'($urandom), 1'b1, 1'b1, 1'b0);
    random_phase(42, DEB_W'($urandom_range(1, 8)), LVL_W'($urandom), 8'hFF, 1'b1,
                 1'b0, 1'b1);
    steady = 1'b1;
    random_phase(42, 16'd20, 8'hFF, 8'h00, 1'b1, 1'b0, 1'b0);
    steady = 1'b0;
    random_phase(36, 16'hFFFF, 8'hFF, LVL_W'($urandom), 1'b1, 1'b0, 1'b0);
    random_phase(42, DEB_W'($urandom_range(0, 15)), LVL_W'($urandom), LVL_W'($urandom),
                 1'b1, 1'b0, 1'b0);
    random_phase(12, 16'd2, 8'hFF, LVL_W'($urandom), 1'b0, 1'b0, 1'b0);
    random_phase(36, 16'd3, 8'hFF, LVL_W'($urandom), 1'b1, 1'b0, 1'b0);

    wait_drained(30);
    if (tracker.mismatches == 0) begin
      $display("multi_channel_debouncer_tb OK");
    end else begin
      $display("multi_channel_debouncer_tb NOT OK");
    end
    $finish;
  end

endmodule
